// File: sv/s5rp_pkg.sv
package s5rp_pkg;

	localparam logic [7:0] SOCKS_VERSION = 8'd5;
	localparam logic [7:0] CMD_CONNECT   = 8'd1;
	localparam logic [7:0] CMD_UDP_ASSOC = 8'd3;
	localparam logic [7:0] ATYP_IPV4     = 8'd1;
	localparam logic [7:0] ATYP_DOMAIN   = 8'd3;
	localparam logic [7:0] ATYP_IPV6     = 8'd4;
	localparam logic [7:0] LEN_IPV4      = 8'd4;
	localparam logic [7:0] LEN_IPV6      = 8'd16;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_BAD_VER  = 3'd1;
	localparam logic [2:0] ST_BAD_CMD  = 3'd2;
	localparam logic [2:0] ST_BAD_ATYP = 3'd3;
	localparam logic [2:0] ST_JUNK     = 3'd4;
	localparam logic [2:0] ST_BAD_UDP  = 3'd5;

	typedef enum logic [13:0] {
		PH_IDLE    = 14'b00000000000001,
		PH_VER     = 14'b00000000000010,
		PH_CMD     = 14'b00000000000100,
		PH_RSV     = 14'b00000000001000,
		PH_URSV0   = 14'b00000000010000,
		PH_URSV1   = 14'b00000000100000,
		PH_FRAG    = 14'b00000001000000,
		PH_ATYP    = 14'b00000010000000,
		PH_ALEN    = 14'b00000100000000,
		PH_ADDR    = 14'b00001000000000,
		PH_PORT_HI = 14'b00010000000000,
		PH_PORT_LO = 14'b00100000000000,
		PH_FINISH  = 14'b01000000000000,
		PH_PAYLOAD = 14'b10000000000000
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       first_byte;
		logic       last_byte;
		logic       udp_header;
	} in_word_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [7:0]  command;
		logic [7:0]  address_type;
		logic [7:0]  addr_byte;
		logic [7:0]  addr_index;
		logic        addr_valid;
		logic [15:0] port;
		logic        complete;
	} out_word_t;

endpackage

// File: sv/s5rp_if.sv
interface s5rp_in_if;
	logic                valid;
	logic                ready;
	s5rp_pkg::in_word_t  data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface s5rp_out_if;
	logic                valid;
	logic                ready;
	s5rp_pkg::out_word_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// File: sv/s5rp_core.sv
module s5rp_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  s5rp_pkg::in_word_t  word,
	output s5rp_pkg::out_word_t result
);

	s5rp_pkg::phase_t phase_q, phase_d;
	logic        udp_q, udp_d;
	logic [7:0]  cmd_q, cmd_d;
	logic [7:0]  atyp_q, atyp_d;
	logic [7:0]  idx_q, idx_d;
	logic [7:0]  len_q, len_d;
	logic [15:0] port_q, port_d;
	logic        done_q, done_d;

	always_comb begin
		logic [7:0] c;
		logic [7:0] idx_inc;
		c = word.data_byte;
		phase_d = phase_q;
		udp_d = udp_q;
		cmd_d = cmd_q;
		atyp_d = atyp_q;
		idx_d = idx_q;
		len_d = len_q;
		port_d = port_q;
		done_d = done_q;
		result = '0;
		result.status = s5rp_pkg::ST_OK;

		// restart on the first word of a message
		if (word.first_byte) begin
			udp_d = word.udp_header;
			cmd_d = '0;
			atyp_d = '0;
			idx_d = '0;
			len_d = '0;
			port_d = '0;
			done_d = 1'b0;
			phase_d = word.udp_header ? s5rp_pkg::PH_URSV0 : s5rp_pkg::PH_VER;
		end

		idx_inc = idx_d + 8'd1;

		case (phase_d)
			s5rp_pkg::PH_VER: begin
				if (c != s5rp_pkg::SOCKS_VERSION) begin
					result.status = s5rp_pkg::ST_BAD_VER;
					phase_d = s5rp_pkg::PH_IDLE;
				end else begin
					phase_d = s5rp_pkg::PH_CMD;
				end
			end
			s5rp_pkg::PH_CMD: begin
				if (c != s5rp_pkg::CMD_CONNECT && c != s5rp_pkg::CMD_UDP_ASSOC) begin
					result.status = s5rp_pkg::ST_BAD_CMD;
					phase_d = s5rp_pkg::PH_IDLE;
				end else begin
					cmd_d = c;
					phase_d = s5rp_pkg::PH_RSV;
				end
			end
			s5rp_pkg::PH_RSV: begin
				phase_d = s5rp_pkg::PH_ATYP;
			end
			s5rp_pkg::PH_URSV0, s5rp_pkg::PH_URSV1: begin
				if (word.last_byte) begin
					result.status = s5rp_pkg::ST_BAD_UDP;
					phase_d = s5rp_pkg::PH_IDLE;
				end else if (phase_d == s5rp_pkg::PH_URSV0) begin
					phase_d = s5rp_pkg::PH_URSV1;
				end else begin
					phase_d = s5rp_pkg::PH_FRAG;
				end
			end
			s5rp_pkg::PH_FRAG: begin
				if (c != 8'd0) begin
					result.status = s5rp_pkg::ST_BAD_UDP;
					phase_d = s5rp_pkg::PH_IDLE;
				end else begin
					phase_d = s5rp_pkg::PH_ATYP;
				end
			end
			s5rp_pkg::PH_ATYP: begin
				atyp_d = c;
				idx_d = '0;
				if (c == s5rp_pkg::ATYP_IPV4) begin
					len_d = s5rp_pkg::LEN_IPV4;
					phase_d = s5rp_pkg::PH_ADDR;
				end else if (c == s5rp_pkg::ATYP_DOMAIN) begin
					phase_d = s5rp_pkg::PH_ALEN;
				end else if (c == s5rp_pkg::ATYP_IPV6) begin
					len_d = s5rp_pkg::LEN_IPV6;
					phase_d = s5rp_pkg::PH_ADDR;
				end else begin
					result.status = s5rp_pkg::ST_BAD_ATYP;
					phase_d = s5rp_pkg::PH_IDLE;
				end
			end
			s5rp_pkg::PH_ALEN: begin
				idx_d = '0;
				len_d = c;
				phase_d = (c == 8'd0) ? s5rp_pkg::PH_PORT_HI : s5rp_pkg::PH_ADDR;
			end
			s5rp_pkg::PH_ADDR: begin
				result.addr_byte = c;
				result.addr_index = idx_d;
				result.addr_valid = 1'b1;
				if (idx_inc == len_d) begin
					idx_d = '0;
					phase_d = s5rp_pkg::PH_PORT_HI;
				end else begin
					idx_d = idx_inc;
				end
			end
			s5rp_pkg::PH_PORT_HI: begin
				port_d = {c, 8'd0};
				phase_d = s5rp_pkg::PH_PORT_LO;
			end
			s5rp_pkg::PH_PORT_LO: begin
				port_d = {port_d[15:8], c};
				done_d = 1'b1;
				phase_d = udp_d ? s5rp_pkg::PH_PAYLOAD : s5rp_pkg::PH_FINISH;
			end
			s5rp_pkg::PH_FINISH: begin
				result.status = s5rp_pkg::ST_JUNK;
				phase_d = s5rp_pkg::PH_IDLE;
			end
			default: begin
			end
		endcase

		if (word.last_byte) begin
			phase_d = s5rp_pkg::PH_IDLE;
		end

		result.command = cmd_d;
		result.address_type = atyp_d;
		result.port = port_d;
		result.complete = done_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= s5rp_pkg::PH_IDLE;
			udp_q <= 1'b0;
			cmd_q <= '0;
			atyp_q <= '0;
			idx_q <= '0;
			len_q <= '0;
			port_q <= '0;
			done_q <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_d;
			udp_q <= udp_d;
			cmd_q <= cmd_d;
			atyp_q <= atyp_d;
			idx_q <= idx_d;
			len_q <= len_d;
			port_q <= port_d;
			done_q <= done_d;
		end
	end

endmodule

// File: sv/s5rp_out_reg.sv
module s5rp_out_reg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  s5rp_pkg::out_word_t next_word,
	input  logic                out_ready,
	output logic                out_valid,
	output s5rp_pkg::out_word_t out_word,
	output logic                can_load
);

	logic                valid_q;
	s5rp_pkg::out_word_t word_q;

	assign can_load = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_word = word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_load) begin
			valid_q <= load;
		end
	end

	// hold the word while the sink stalls
	always_ff @(posedge clk) begin
		if (load) begin
			word_q <= next_word;
		end
	end

endmodule

// File: sv/socks5_request_header_parser.sv
// channel | dir | payload                                              | handshake
// din     | in  | data_byte, first_byte, last_byte, udp_header         | valid/ready
// dout    | out | status, command, address_type, addr_byte,            | valid/ready
//         |     | addr_index, addr_valid, port, complete               |
//
// One result word per input word; it is registered and appears in the cycle after the word is taken.
// A new word is taken every cycle while din.ready is high; the parse state updates in the same cycle.
// din.ready is low only while a result waits in the output register and
// dout.ready is low; the output register holds that word until taken.
// arst_n clears the parse state to idle and empties the output register.
module socks5_request_header_parser (
	input  logic clk,
	input  logic arst_n,
	s5rp_in_if.sink    din,
	s5rp_out_if.source dout
);

	logic                take;
	logic                can_load;
	s5rp_pkg::out_word_t next_word;

	assign din.ready = can_load;
	assign take = din.valid && can_load;

	s5rp_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (take),
		.word   (din.data),
		.result (next_word)
	);

	s5rp_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (take),
		.next_word (next_word),
		.out_ready (dout.ready),
		.out_valid (dout.valid),
		.out_word  (dout.data),
		.can_load  (can_load)
	);

endmodule

// File: sv/s5rp_checker.sv
module s5rp_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input s5rp_pkg::out_word_t out_word
);

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_word))
		else $error("result word changed while stalled");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output register");

	a_take_fills: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("taken word produced no result");

	a_addr_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.addr_valid |->
			out_word.status == s5rp_pkg::ST_OK && !out_word.complete)
		else $error("address word with error or after port");

	a_bad_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.status == s5rp_pkg::ST_BAD_CMD |-> out_word.command == 8'd0)
		else $error("rejected command was latched");

endmodule

bind socks5_request_header_parser s5rp_checker u_s5rp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (din.valid),
	.in_ready  (din.ready),
	.out_valid (dout.valid),
	.out_ready (dout.ready),
	.out_word  (dout.data)
);
